/* rtl/core/pfs_pkg.sv */
// Shared types, sizes and codes of the priority flow scheduler.
package pfs_pkg;

   // Number of wait queue slots; a power of two so that slot pointers wrap.
   localparam int QUEUE_DEPTH = 32;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int KEY_W       = 48;
   localparam int ID_W        = 8;
   localparam int WAIT_W      = 6;
   localparam int OUTCOME_W   = 3;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 16;
   localparam int RSP_PAD_W   = RSP_DATA_W - WAIT_W - ID_W;

   // Most significant field first, so a plain unsigned compare gives the service order.
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] arrive;
      logic [15:0] xmit;
      logic [7:0]  id;
   } key_type;

   typedef enum logic {
      REQ_ACQUIRE = 1'b0,
      REQ_RELEASE = 1'b1
   } req_kind_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_GRANTED    = 3'd0,
      OUT_QUEUED     = 3'd1,
      OUT_DROPPED    = 3'd2,
      OUT_IDLE_NOW   = 3'd3,
      OUT_IGNORED    = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_PLACE,
      ST_POP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      key_type          data;
   } ram_wr_type;

endpackage

/* rtl/core/pfs_queue_ram.sv */
// Wait queue storage: one write port, one read port with registered read data.
module pfs_queue_ram (
   input  logic                      clock,
   input  pfs_pkg::ram_wr_type       wr,
   input  logic [pfs_pkg::PTR_W-1:0] rd_addr,
   output pfs_pkg::key_type          rd_data
);

   pfs_pkg::key_type mem [pfs_pkg::QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/pfs_key_cmp.sv */
// Key comparator: true when flow a is served before flow b.
module pfs_key_cmp (
   input  pfs_pkg::key_type a,
   input  pfs_pkg::key_type b,
   output logic             a_first
);

   logic [pfs_pkg::KEY_W-1:0] a_bits;
   logic [pfs_pkg::KEY_W-1:0] b_bits;

   assign a_bits  = a;
   assign b_bits  = b;
   assign a_first = a_bits < b_bits;

endmodule

/* rtl/core/priority_flow_scheduler.sv */
// Top level of the priority flow scheduler: sequencer, queue pointers and result register.
// The scheduler takes one event at a time. A grant on an idle channel, a drop, an idle
// release and a release with an empty queue go from the request transfer through the
// DONE state to the result; a release that hands the channel to the queue head first
// passes through the POP state, which takes the head from the queue memory read. A queued
// request walks the queue from its tail toward its head, one slot per cycle through a
// single key comparator, moving each later flow back by one slot (a request that finds all
// 32 slots taken is dropped). The next request is taken as soon as the result is in the
// output register, even while that result is still waiting to be taken.
module priority_flow_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // Fields from bit 0: flow_priority[7:0], arrival_tenths[15:0], transmit_tenths[15:0],
   // flow_id[7:0].
   input  logic [pfs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Fields from bit 0: req_type.
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // Fields from bit 0: granted_id[7:0], waiting_count[5:0], two zero bits.
   output logic [pfs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Fields from bit 0: outcome[2:0].
   output logic [pfs_pkg::OUTCOME_W-1:0]      rsp_tuser
);

   pfs_pkg::state_type          state_ff, state_in;
   logic                        busy_ff, busy_in;
   logic [pfs_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [pfs_pkg::PTR_W-1:0]   head_ff, head_in;
   logic [pfs_pkg::CNT_W-1:0]   idx_ff, idx_in;
   pfs_pkg::key_type            new_key_ff, new_key_in;
   pfs_pkg::outcome_type        outcome_ff, outcome_in;
   logic [pfs_pkg::ID_W-1:0]    gid_ff, gid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [pfs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [pfs_pkg::OUTCOME_W-1:0]  rsp_user_ff, rsp_user_in;

   pfs_pkg::ram_wr_type         ram_wr;
   logic [pfs_pkg::PTR_W-1:0]   ram_rd_addr;
   pfs_pkg::key_type            ram_rd_data;
   pfs_pkg::key_type            req_key;
   logic                        new_first;
   logic                        req_fire;
   logic                        rsp_free;
   pfs_pkg::req_kind_type       req_kind;

   assign req_key.prio   = req_tdata[7:0];
   assign req_key.arrive = req_tdata[23:8];
   assign req_key.xmit   = req_tdata[39:24];
   assign req_key.id     = req_tdata[47:40];
   assign req_kind       = pfs_pkg::req_kind_type'(req_tuser);

   assign req_tready = (state_ff == pfs_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   pfs_queue_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   pfs_key_cmp u_cmp (
      .a       (new_key_ff),
      .b       (ram_rd_data),
      .a_first (new_first)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == pfs_pkg::REQ_ACQUIRE) begin
                  if (!busy_ff && count_ff == '0) begin
                     state_in = pfs_pkg::ST_DONE;
                  end else if (count_ff == pfs_pkg::CNT_W'(pfs_pkg::QUEUE_DEPTH)) begin
                     state_in = pfs_pkg::ST_DONE;
                  end else if (count_ff == '0) begin
                     state_in = pfs_pkg::ST_PLACE;
                  end else begin
                     state_in = pfs_pkg::ST_SHIFT;
                  end
               end else begin
                  if (busy_ff && count_ff != '0) begin
                     state_in = pfs_pkg::ST_POP;
                  end else begin
                     state_in = pfs_pkg::ST_DONE;
                  end
               end
            end
         end
         pfs_pkg::ST_SHIFT: begin
            if (!new_first || idx_ff == pfs_pkg::CNT_W'(1)) begin
               state_in = pfs_pkg::ST_PLACE;
            end
         end
         pfs_pkg::ST_PLACE: state_in = pfs_pkg::ST_DONE;
         pfs_pkg::ST_POP:   state_in = pfs_pkg::ST_DONE;
         pfs_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = pfs_pkg::ST_IDLE;
            end
         end
         default: state_in = pfs_pkg::ST_IDLE;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      busy_in      = busy_ff;
      count_in     = count_ff;
      head_in      = head_ff;
      idx_in       = idx_ff;
      new_key_in   = new_key_ff;
      outcome_in   = outcome_ff;
      gid_in       = gid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_wr.en    = 1'b0;
      ram_wr.addr  = head_ff + pfs_pkg::PTR_W'(idx_ff);
      ram_wr.data  = new_key_ff;
      ram_rd_addr  = head_ff;
      case (state_ff)
         pfs_pkg::ST_IDLE: begin
            if (req_fire) begin
               new_key_in = req_key;
               gid_in     = '0;
               idx_in     = count_ff;
               ram_rd_addr = head_ff + pfs_pkg::PTR_W'(count_ff - pfs_pkg::CNT_W'(1));
               if (req_kind == pfs_pkg::REQ_ACQUIRE) begin
                  if (!busy_ff && count_ff == '0) begin
                     busy_in    = 1'b1;
                     gid_in     = req_key.id;
                     outcome_in = pfs_pkg::OUT_GRANTED;
                  end else if (count_ff == pfs_pkg::CNT_W'(pfs_pkg::QUEUE_DEPTH)) begin
                     outcome_in = pfs_pkg::OUT_DROPPED;
                  end
               end else begin
                  ram_rd_addr = head_ff;
                  if (!busy_ff) begin
                     outcome_in = pfs_pkg::OUT_IGNORED;
                  end else if (count_ff == '0) begin
                     busy_in    = 1'b0;
                     outcome_in = pfs_pkg::OUT_IDLE_NOW;
                  end
               end
            end
         end
         pfs_pkg::ST_SHIFT: begin
            // The read data holds the slot just ahead of the hole at idx.
            if (new_first) begin
               ram_wr.en   = 1'b1;
               ram_wr.data = ram_rd_data;
               idx_in      = idx_ff - pfs_pkg::CNT_W'(1);
               ram_rd_addr = head_ff + pfs_pkg::PTR_W'(idx_ff - pfs_pkg::CNT_W'(2));
            end
         end
         pfs_pkg::ST_PLACE: begin
            ram_wr.en  = 1'b1;
            count_in   = count_ff + pfs_pkg::CNT_W'(1);
            outcome_in = pfs_pkg::OUT_QUEUED;
         end
         pfs_pkg::ST_POP: begin
            gid_in     = ram_rd_data.id;
            head_in    = head_ff + pfs_pkg::PTR_W'(1);
            count_in   = count_ff - pfs_pkg::CNT_W'(1);
            outcome_in = pfs_pkg::OUT_GRANTED;
         end
         pfs_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{pfs_pkg::RSP_PAD_W{1'b0}},
                               pfs_pkg::WAIT_W'(count_ff), gid_ff};
               rsp_user_in  = outcome_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfs_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      new_key_ff  <= new_key_in;
      outcome_ff  <= outcome_in;
      gid_ff      <= gid_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pfs_pkg::CNT_W'(pfs_pkg::QUEUE_DEPTH))
      else $error("wait queue count exceeds its depth");

   a_waiters_busy: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> busy_ff)
      else $error("flows wait while the channel is idle");

   a_shift_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfs_pkg::ST_SHIFT) |-> (idx_ff != '0 && idx_ff <= count_ff))
      else $error("insertion walk index out of range");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != pfs_pkg::ST_IDLE))
      else $error("accepted transfer produced no work");

   a_place_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfs_pkg::ST_PLACE) |=> (count_ff == $past(count_ff) + pfs_pkg::CNT_W'(1)))
      else $error("queued flow did not raise the count");

endmodule
